// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/lss_pkg.sv
// ----------------------------------------------------------------------------
// Light sample shading package
// Widths, register indexes, light modes and pipeline sideband types.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

    localparam int W_COORD = 20;
    localparam int W_VEC   = 16;
    localparam int W_WI    = 21;
    localparam int W_D2    = 42;
    localparam int W_D     = 21;
    localparam int W_DOT   = 40;
    localparam int W_TDIR  = 34;
    localparam int W_COEF  = 24;
    localparam int W_CH    = 16;
    localparam int W_NUM   = 49;
    localparam int W_DEN   = 52;
    localparam int W_QUO   = 33;
    localparam int W_Q16   = 18;
    localparam int W_ATT   = 33;
    localparam int DIR_SHIFT = 14;
    localparam int COS_SHIFT = 9;
    localparam int FRAC_SHIFT = 16;

    localparam logic [1:0] MODE_DIR   = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_SPOT  = 2'd2;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_RAD   = 3'd1;
    localparam logic [2:0] REG_POS   = 3'd2;
    localparam logic [2:0] REG_DIR   = 3'd3;
    localparam logic [2:0] REG_CONE  = 3'd4;
    localparam logic [2:0] REG_KC    = 3'd5;
    localparam logic [2:0] REG_KL    = 3'd6;
    localparam logic [2:0] REG_KQ    = 3'd7;

    localparam logic [W_COEF-1:0] KL_RESET = 24'd131;
    localparam logic [W_Q16-1:0]  CAP_Q16  = 18'd131072;
    localparam logic [W_Q16-1:0]  ONE_Q16  = 18'd65536;
    localparam logic [W_ATT-1:0]  ATT_ONE  = 33'd65536;
    localparam logic [W_ATT-1:0]  ATT_MAX  = 33'h1_0000_0000;

    typedef struct packed {
        logic [1:0]               mode;
        logic [W_D2-1:0]          d2;
        logic signed [W_DOT-1:0]  dn;
        logic signed [W_DOT-1:0]  a;
        logic signed [W_TDIR-1:0] t;
    } sq_side_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic                     zero;
        logic                     outside;
        logic                     dn_pos;
        logic                     a_neg;
        logic                     den_zero;
        logic signed [W_TDIR-1:0] t;
    } div_side_t;

    typedef struct packed {
        logic             kill;
        logic             outside;
        logic [W_Q16-1:0] cosq;
        logic [W_Q16-1:0] m;
        logic [W_Q16-1:0] p;
        logic [W_ATT-1:0] atten;
    } pw_t;

    function automatic logic [W_Q16-1:0] cap_q16(input logic ovf, input logic [W_QUO-1:0] q);
        cap_q16 = (ovf || (q > W_QUO'(CAP_Q16))) ? CAP_Q16 : q[W_Q16-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/lss_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, remainder form, with a sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_isqrt_pipe #(
    parameter int XW = 42,
    parameter int SW = 1
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [XW-1:0]           in_x,
    input  wire logic [SW-1:0]           in_side,
    output logic                         out_valid,
    output logic [(XW+1)/2-1:0]          out_root,
    output logic [SW-1:0]                out_side
);

    localparam int RW = (XW + 1) / 2;

    logic          vld_reg  [RW];
    logic [XW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] side_reg [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int K = RW - 1 - j;
        logic          vld_in;
        logic [XW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] side_in;
        logic [RW:0]   trial;
        logic [XW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (j == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_x;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else begin : g_chain
            assign vld_in  = vld_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb
        begin
            trial     = {root_in, 1'b0} | ((RW+1)'(1) << K);
            rem_next  = rem_in;
            root_next = root_in;
            if ((rem_in >> K) >= XW'(trial))
            begin
                rem_next  = rem_in - (XW'(trial) << K);
                root_next = root_in | (RW'(1) << K);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

`default_nettype wire

// File: hdl/lss_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined multi-lane divider
// Restoring division, one quotient bit per stage, with overflow detect.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_div_pipe #(
    parameter int NL = 3,
    parameter int NW = 49,
    parameter int DW = 52,
    parameter int QW = 33,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num [NL],
    input  wire logic [DW-1:0] in_den [NL],
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QW-1:0]      out_quo [NL],
    output logic               out_ovf [NL],
    output logic [SW-1:0]      out_side
);

    localparam int CW = (NW > DW) ? NW : DW;

    logic          vld_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [NW-1:0] rem_reg  [QW][NL];
    logic [DW-1:0] den_reg  [QW][NL];
    logic [QW-1:0] quo_reg  [QW][NL];
    logic          ovf_reg  [QW][NL];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic          vld_in;
        logic [SW-1:0] side_in;

        if (j == 0) begin : g_first_ctl
            assign vld_in  = in_valid;
            assign side_in = in_side;
        end
        else begin : g_chain_ctl
            assign vld_in  = vld_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [NW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic          ovf_in;
            logic          take;
            logic [NW-1:0] rem_next;
            logic [QW-1:0] quo_next;

            if (j == 0) begin : g_first
                assign rem_in = in_num[l];
                assign den_in = in_den[l];
                assign quo_in = '0;
                assign ovf_in = CW'(in_num[l] >> QW) >= CW'(in_den[l]);
            end
            else begin : g_chain
                assign rem_in = rem_reg[j-1][l];
                assign den_in = den_reg[j-1][l];
                assign quo_in = quo_reg[j-1][l];
                assign ovf_in = ovf_reg[j-1][l];
            end

            always_comb
            begin
                take     = CW'(rem_in >> K) >= CW'(den_in);
                rem_next = rem_in;
                quo_next = quo_in;
                if (take)
                begin
                    rem_next = rem_in - (NW'(den_in) << K);
                    quo_next = quo_in | (QW'(1) << K);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j][l] <= rem_next;
                    den_reg[j][l] <= den_in;
                    quo_reg[j][l] <= quo_next;
                    ovf_reg[j][l] <= ovf_in;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_in;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            out_quo[l] = quo_reg[QW-1][l];
            out_ovf[l] = ovf_reg[QW-1][l];
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

// File: hdl/light_source_sample_shading_top.sv
// ----------------------------------------------------------------------------
// Light sample shading top level
// Incoming RGB light at a surface point from one directional, point or spot
// light, with distance attenuation and cone falloff.
//
// Usage:
//  s_* stream carries one surface point and unit normal per transaction;
//  m_* stream returns one saturated RGB result and the outside-cone flag.
//  cfg_* writes one light register per transaction; cfg_ready is always high.
//  Write configuration only while no transaction is in flight.
//  The pipeline has 3 setup stages, 21 square root stages, 2 attenuation
//  stages, 33 divider stages, SPOT_EXPONENT power stages and 3 channel
//  scaling stages. One transaction enters per cycle while s_tready is high.
//  The whole pipeline advances together; when the receiver stalls with a
//  result waiting, s_tready drops and every stage holds.
//  Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module light_source_sample_shading_top #(
    parameter int SPOT_EXPONENT = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [111:0] s_tdata,   // surface_x, surface_y, surface_z, normal_x, normal_y, normal_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata,   // light_r, light_g, light_b, outside_cone
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [59:0]  cfg_data
);

    localparam int  NE       = SPOT_EXPONENT;
    localparam logic SPOT_ODD = (SPOT_EXPONENT % 2) != 0;
    localparam int  W_KLD    = lss_pkg::W_COEF + lss_pkg::W_D;
    localparam int  W_KQH    = lss_pkg::W_COEF + lss_pkg::W_D2 - lss_pkg::FRAC_SHIFT;
    localparam int  W_KQL    = lss_pkg::W_COEF + lss_pkg::FRAC_SHIFT;
    localparam int  W_CD     = lss_pkg::W_VEC + lss_pkg::W_D + 1;
    localparam int  W_TSH    = lss_pkg::W_TDIR - lss_pkg::DIR_SHIFT;

    logic [1:0]                 mode_reg;
    logic [47:0]                rad_reg;
    logic [59:0]                pos_reg;
    logic [47:0]                dir_reg;
    logic signed [15:0]         cone_reg;
    logic [lss_pkg::W_COEF-1:0] kc_reg;
    logic [lss_pkg::W_COEF-1:0] kl_reg;
    logic [lss_pkg::W_COEF-1:0] kq_reg;

    logic en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lss_pkg::MODE_DIR;
            rad_reg  <= '0;
            pos_reg  <= '0;
            dir_reg  <= '0;
            cone_reg <= '0;
            kc_reg   <= '0;
            kl_reg   <= lss_pkg::KL_RESET;
            kq_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lss_pkg::REG_MODE: mode_reg <= cfg_data[1:0];
                lss_pkg::REG_RAD:  rad_reg  <= cfg_data[47:0];
                lss_pkg::REG_POS:  pos_reg  <= cfg_data[59:0];
                lss_pkg::REG_DIR:  dir_reg  <= cfg_data[47:0];
                lss_pkg::REG_CONE: cone_reg <= cfg_data[15:0];
                lss_pkg::REG_KC:   kc_reg   <= cfg_data[23:0];
                lss_pkg::REG_KL:   kl_reg   <= cfg_data[23:0];
                lss_pkg::REG_KQ:   kq_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // stage 1: offset to light
    logic signed [lss_pkg::W_COORD-1:0] pos_c  [3];
    logic signed [lss_pkg::W_COORD-1:0] surf_c [3];
    logic signed [lss_pkg::W_VEC-1:0]   nrm_c  [3];
    logic signed [lss_pkg::W_VEC-1:0]   dir_c  [3];
    logic                               vld1_reg;
    logic signed [lss_pkg::W_WI-1:0]    wi1_reg [3];
    logic signed [lss_pkg::W_VEC-1:0]   n1_reg  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_c[i]  = pos_reg[i*lss_pkg::W_COORD +: lss_pkg::W_COORD];
            surf_c[i] = s_tdata[i*lss_pkg::W_COORD +: lss_pkg::W_COORD];
            nrm_c[i]  = s_tdata[3*lss_pkg::W_COORD + i*lss_pkg::W_VEC +: lss_pkg::W_VEC];
            dir_c[i]  = dir_reg[i*lss_pkg::W_VEC +: lss_pkg::W_VEC];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wi1_reg[i] <= lss_pkg::W_WI'(pos_c[i]) - lss_pkg::W_WI'(surf_c[i]);
                n1_reg[i]  <= nrm_c[i];
            end
        end
    end

    // stage 2: products
    logic signed [lss_pkg::W_D2-1:0]                wsq_next [3];
    logic signed [lss_pkg::W_VEC+lss_pkg::W_WI-1:0] nw_next  [3];
    logic signed [lss_pkg::W_VEC+lss_pkg::W_WI-1:0] dw_next  [3];
    logic signed [2*lss_pkg::W_VEC-1:0]             nd_next  [3];
    logic                                           vld2_reg;
    logic [lss_pkg::W_D2-1:0]                       wsq2_reg [3];
    logic signed [lss_pkg::W_VEC+lss_pkg::W_WI-1:0] nw2_reg  [3];
    logic signed [lss_pkg::W_VEC+lss_pkg::W_WI-1:0] dw2_reg  [3];
    logic signed [2*lss_pkg::W_VEC-1:0]             nd2_reg  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wsq_next[i] = wi1_reg[i] * wi1_reg[i];
            nw_next[i]  = n1_reg[i] * wi1_reg[i];
            dw_next[i]  = dir_c[i] * wi1_reg[i];
            nd_next[i]  = n1_reg[i] * dir_c[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wsq2_reg[i] <= $unsigned(wsq_next[i]);
                nw2_reg[i]  <= nw_next[i];
                dw2_reg[i]  <= dw_next[i];
                nd2_reg[i]  <= nd_next[i];
            end
        end
    end

    // stage 3: dot products and squared distance
    lss_pkg::sq_side_t sq3_next;
    lss_pkg::sq_side_t sq3_reg;
    logic              vld3_reg;

    always_comb
    begin
        sq3_next.mode = mode_reg;
        sq3_next.d2   = wsq2_reg[0] + wsq2_reg[1] + wsq2_reg[2];
        sq3_next.dn   = lss_pkg::W_DOT'(nw2_reg[0]) + lss_pkg::W_DOT'(nw2_reg[1])
                      + lss_pkg::W_DOT'(nw2_reg[2]);
        sq3_next.a    = -(lss_pkg::W_DOT'(dw2_reg[0]) + lss_pkg::W_DOT'(dw2_reg[1])
                      + lss_pkg::W_DOT'(dw2_reg[2]));
        sq3_next.t    = -(lss_pkg::W_TDIR'(nd2_reg[0]) + lss_pkg::W_TDIR'(nd2_reg[1])
                      + lss_pkg::W_TDIR'(nd2_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq3_reg <= sq3_next;
        end
    end

    // distance
    logic                                   sq_vld;
    logic [lss_pkg::W_D-1:0]                sq_root;
    logic [$bits(lss_pkg::sq_side_t)-1:0]   sq_side_raw;
    lss_pkg::sq_side_t                      sqo;

    lss_isqrt_pipe #(
        .XW (lss_pkg::W_D2),
        .SW ($bits(lss_pkg::sq_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld3_reg),
        .in_x      (sq3_reg.d2),
        .in_side   (sq3_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side_raw)
    );

    assign sqo = lss_pkg::sq_side_t'(sq_side_raw);

    // attenuation stage 1: coefficient products and cone bound
    logic                        vldp1_reg;
    lss_pkg::sq_side_t           sqp1_reg;
    logic [lss_pkg::W_D-1:0]     dp1_reg;
    logic signed [W_CD-1:0]      cd_next;
    logic signed [W_CD-1:0]      cdp1_reg;
    logic [W_KLD-1:0]            kldp1_reg;
    logic [W_KQH-1:0]            kqhp1_reg;
    logic [W_KQL-1:0]            kqlp1_reg;

    assign cd_next = cone_reg * $signed({1'b0, sq_root});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldp1_reg <= 1'b0;
        end
        else if (en)
        begin
            vldp1_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqp1_reg  <= sqo;
            dp1_reg   <= sq_root;
            cdp1_reg  <= cd_next;
            kldp1_reg <= kl_reg * sq_root;
            kqhp1_reg <= kq_reg * sqo.d2[lss_pkg::W_D2-1:lss_pkg::FRAC_SHIFT];
            kqlp1_reg <= kq_reg * sqo.d2[lss_pkg::FRAC_SHIFT-1:0];
        end
    end

    // attenuation stage 2: denominator, cone test, divider operands
    logic [lss_pkg::W_DEN-1:0]  denom_next;
    logic [lss_pkg::W_DOT-1:0]  mag_next;
    lss_pkg::div_side_t         ds_next;
    logic                       vldp2_reg;
    lss_pkg::div_side_t         dsp2_reg;
    logic [lss_pkg::W_NUM-1:0]  nump2_reg [3];
    logic [lss_pkg::W_DEN-1:0]  denp2_reg [3];

    always_comb
    begin
        denom_next = lss_pkg::W_DEN'(kc_reg)
                   + lss_pkg::W_DEN'(kldp1_reg[W_KLD-1:8])
                   + lss_pkg::W_DEN'(kqhp1_reg)
                   + lss_pkg::W_DEN'(kqlp1_reg[W_KQL-1:lss_pkg::FRAC_SHIFT]);
        mag_next   = sqp1_reg.a[lss_pkg::W_DOT-1] ? $unsigned(-sqp1_reg.a)
                                                  : $unsigned(sqp1_reg.a);
        ds_next.mode     = sqp1_reg.mode;
        ds_next.zero     = sqp1_reg.d2 == '0;
        ds_next.outside  = (sqp1_reg.mode == lss_pkg::MODE_SPOT) && (sqp1_reg.d2 != '0)
                         && (sqp1_reg.a < lss_pkg::W_DOT'(cdp1_reg));
        ds_next.dn_pos   = sqp1_reg.dn > 0;
        ds_next.a_neg    = sqp1_reg.a[lss_pkg::W_DOT-1];
        ds_next.den_zero = denom_next == '0;
        ds_next.t        = sqp1_reg.t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldp2_reg <= 1'b0;
        end
        else if (en)
        begin
            vldp2_reg <= vldp1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsp2_reg     <= ds_next;
            nump2_reg[0] <= lss_pkg::W_NUM'($unsigned(sqp1_reg.dn)) << lss_pkg::COS_SHIFT;
            nump2_reg[1] <= lss_pkg::W_NUM'(mag_next) << lss_pkg::COS_SHIFT;
            nump2_reg[2] <= lss_pkg::W_NUM'(lss_pkg::ATT_MAX);
            denp2_reg[0] <= lss_pkg::W_DEN'(dp1_reg);
            denp2_reg[1] <= lss_pkg::W_DEN'(dp1_reg);
            denp2_reg[2] <= denom_next;
        end
    end

    // cosine, cone cosine and attenuation quotients
    logic                                  dv_vld;
    logic [lss_pkg::W_QUO-1:0]             dv_quo [3];
    logic                                  dv_ovf [3];
    logic [$bits(lss_pkg::div_side_t)-1:0] dv_side_raw;
    lss_pkg::div_side_t                    dvo;

    lss_div_pipe #(
        .NL (3),
        .NW (lss_pkg::W_NUM),
        .DW (lss_pkg::W_DEN),
        .QW (lss_pkg::W_QUO),
        .SW ($bits(lss_pkg::div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vldp2_reg),
        .in_num    (nump2_reg),
        .in_den    (denp2_reg),
        .in_side   (dsp2_reg),
        .out_valid (dv_vld),
        .out_quo   (dv_quo),
        .out_ovf   (dv_ovf),
        .out_side  (dv_side_raw)
    );

    assign dvo = lss_pkg::div_side_t'(dv_side_raw);

    // cone power stages
    logic         pw_vld_reg [NE];
    lss_pkg::pw_t pw_reg     [NE];

    for (genvar k = 0; k < NE; k++) begin : g_pow
        logic         vld_in;
        lss_pkg::pw_t pw_next;

        if (k == 0) begin : g_first
            logic [W_TSH-1:0]         tsh;
            logic [lss_pkg::W_Q16-1:0] cos_dir;
            logic [lss_pkg::W_Q16-1:0] m_spot;
            logic                     is_spot;

            assign vld_in = dv_vld;

            always_comb
            begin
                tsh     = dvo.t[lss_pkg::W_TDIR-1:lss_pkg::DIR_SHIFT];
                cos_dir = '0;
                if (dvo.t > 0)
                begin
                    cos_dir = (tsh > W_TSH'(lss_pkg::CAP_Q16)) ? lss_pkg::CAP_Q16
                                                               : tsh[lss_pkg::W_Q16-1:0];
                end
                is_spot = dvo.mode == lss_pkg::MODE_SPOT;
                m_spot  = lss_pkg::cap_q16(dv_ovf[1], dv_quo[1]);

                pw_next.outside = dvo.outside;
                pw_next.kill    = (dvo.mode != lss_pkg::MODE_DIR
                                   && dvo.mode != lss_pkg::MODE_POINT && !is_spot)
                                || (dvo.mode != lss_pkg::MODE_DIR && dvo.zero)
                                || dvo.outside
                                || (is_spot && dvo.a_neg && SPOT_ODD);
                if (dvo.mode == lss_pkg::MODE_DIR)
                begin
                    pw_next.cosq  = cos_dir;
                    pw_next.atten = lss_pkg::ATT_ONE;
                end
                else
                begin
                    pw_next.cosq  = dvo.dn_pos ? lss_pkg::cap_q16(dv_ovf[0], dv_quo[0]) : '0;
                    pw_next.atten = dvo.den_zero ? lss_pkg::ATT_MAX : dv_quo[2];
                end
                pw_next.m = is_spot ? m_spot : lss_pkg::ONE_Q16;
                pw_next.p = pw_next.m;
            end
        end
        else begin : g_mul
            logic [2*lss_pkg::W_Q16-1:0] prod;
            logic [lss_pkg::W_Q16+1:0]   psh;

            assign vld_in = pw_vld_reg[k-1];

            always_comb
            begin
                prod    = pw_reg[k-1].p * pw_reg[k-1].m;
                psh     = prod[2*lss_pkg::W_Q16-1:lss_pkg::FRAC_SHIFT];
                pw_next = pw_reg[k-1];
                pw_next.p = (psh > (lss_pkg::W_Q16+2)'(lss_pkg::CAP_Q16)) ? lss_pkg::CAP_Q16
                                                                       : psh[lss_pkg::W_Q16-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pw_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                pw_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pw_reg[k] <= pw_next;
            end
        end
    end

    // channel stage 1: radiance times cosine
    logic                      vldc1_reg;
    lss_pkg::pw_t              pwc1_reg;
    logic [lss_pkg::W_Q16-1:0] v1_reg [3];
    logic [lss_pkg::W_CH+lss_pkg::W_Q16-1:0] v1_prod [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v1_prod[i] = rad_reg[i*lss_pkg::W_CH +: lss_pkg::W_CH] * pw_reg[NE-1].cosq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldc1_reg <= 1'b0;
        end
        else if (en)
        begin
            vldc1_reg <= pw_vld_reg[NE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pwc1_reg <= pw_reg[NE-1];
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i] <= v1_prod[i][lss_pkg::W_CH+lss_pkg::W_Q16-1:lss_pkg::FRAC_SHIFT];
            end
        end
    end

    // channel stage 2: times cone factor
    logic                        vldc2_reg;
    lss_pkg::pw_t                pwc2_reg;
    logic [lss_pkg::W_Q16+1:0]   v2_reg  [3];
    logic [2*lss_pkg::W_Q16-1:0] v2_prod [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v2_prod[i] = v1_reg[i] * pwc1_reg.p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldc2_reg <= 1'b0;
        end
        else if (en)
        begin
            vldc2_reg <= vldc1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pwc2_reg <= pwc1_reg;
            for (int i = 0; i < 3; i++)
            begin
                v2_reg[i] <= v2_prod[i][2*lss_pkg::W_Q16-1:lss_pkg::FRAC_SHIFT];
            end
        end
    end

    // channel stage 3: times attenuation, saturate, output register
    localparam int W_V3 = lss_pkg::W_Q16 + 2 + lss_pkg::W_ATT;

    logic [W_V3-1:0]          v3_prod [3];
    logic [lss_pkg::W_CH-1:0] ch_next [3];
    logic                     out_vld_reg;
    logic [lss_pkg::W_CH-1:0] ch_reg  [3];
    logic                     outside_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v3_prod[i] = v2_reg[i] * pwc2_reg.atten;
            if (pwc2_reg.kill)
            begin
                ch_next[i] = '0;
            end
            else if (|v3_prod[i][W_V3-1:lss_pkg::FRAC_SHIFT+lss_pkg::W_CH])
            begin
                ch_next[i] = '1;
            end
            else
            begin
                ch_next[i] = v3_prod[i][lss_pkg::FRAC_SHIFT+lss_pkg::W_CH-1:lss_pkg::FRAC_SHIFT];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vldc2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            outside_reg <= pwc2_reg.outside;
            for (int i = 0; i < 3; i++)
            begin
                ch_reg[i] <= ch_next[i];
            end
        end
    end

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, outside_reg, ch_reg[2], ch_reg[1], ch_reg[0]};

    `ASSERT_IMP(a_outside_black, m_tvalid && outside_reg,
                ch_reg[0] == '0 && ch_reg[1] == '0 && ch_reg[2] == '0)
    `ASSERT_IMP(a_dir_never_outside, m_tvalid && mode_reg == lss_pkg::MODE_DIR, !outside_reg)
    `ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    `ASSERT_NXT(a_cfg_hold, !cfg_valid && $past(!cfg_valid), $stable(mode_reg))

endmodule

`default_nettype wire
